// ----- rtl/core/eed_pkg.sv -----
// Package for the echo escape decoder: types, byte constants and the result-append helper.
package eed_pkg;

    // Byte values used by the decoder
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_NEWLINE   = 8'h0A;
    localparam logic [7:0] C_BELL      = 8'h07;
    localparam logic [7:0] C_BKSP      = 8'h08;
    localparam logic [7:0] C_ESCAPE    = 8'h1B;
    localparam logic [7:0] C_FORMFEED  = 8'h0C;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_VTAB      = 8'h0B;
    localparam logic [7:0] C_DIGIT_0   = 8'h30;
    localparam logic [7:0] C_DIGIT_7   = 8'h37;
    localparam logic [7:0] C_LETTER_A  = 8'h61;
    localparam logic [7:0] C_LETTER_B  = 8'h62;
    localparam logic [7:0] C_LETTER_C  = 8'h63;
    localparam logic [7:0] C_LETTER_E  = 8'h65;
    localparam logic [7:0] C_LETTER_F  = 8'h66;
    localparam logic [7:0] C_LETTER_N  = 8'h6E;
    localparam logic [7:0] C_LETTER_T  = 8'h74;
    localparam logic [7:0] C_LETTER_V  = 8'h76;

    // Results per item and configuration port layout
    localparam int MAX_RESULTS = 3;
    localparam int CFG_IDX_W   = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPES = 1'b0,
        CFG_NEWLINE = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESCAPE = 3'd1,
        MODE_OCTAL  = 3'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       ends_argument;
        logic       ends_all;
    } t_item;

    typedef struct packed {
        t_mode      mode;
        logic [8:0] oval;
        logic [1:0] odig;
        logic       halt;
    } t_dstate;

    // Results of one item: count plus up to three bytes, first at index 0
    typedef struct packed {
        logic [1:0]                   count;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } t_batch;

    // Append one byte unless output is halted or the batch is full
    function automatic t_batch put_byte(t_batch batch, logic halt, logic [7:0] value);
        t_batch res;
        res = batch;
        if (!halt && batch.count < 2'(MAX_RESULTS)) begin
            res.bytes[batch.count] = value;
            res.count = batch.count + 2'd1;
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/eed_decode.sv -----
// Combinational decode of one argument item into up to three result bytes and the next state.
module eed_decode
    import eed_pkg::*;
(
    input  t_item   i_item,
    input  t_dstate i_state,
    input  logic    i_escapes_enabled,
    input  logic    i_newline_enabled,
    output t_batch  o_batch,
    output t_dstate o_state
);

    t_batch     batch;
    t_dstate    st;
    logic [7:0] b;
    logic       ends;
    logic       do_plain;
    logic [1:0] dig_next;

    always_comb begin
        batch    = '0;
        st       = i_state;
        b        = i_item.data_byte;
        ends     = i_item.ends_argument | i_item.ends_all;
        do_plain = 1'b0;
        dig_next = i_state.odig + 2'd1;

        // Handle the byte according to the current decode mode
        if (i_item.byte_present && !st.halt) begin
            case (st.mode)
                MODE_ESCAPE: begin
                    st.mode = MODE_NORMAL;
                    case (b)
                        C_BACKSLASH: batch = put_byte(batch, st.halt, C_BACKSLASH);
                        C_LETTER_A:  batch = put_byte(batch, st.halt, C_BELL);
                        C_LETTER_B:  batch = put_byte(batch, st.halt, C_BKSP);
                        C_LETTER_C:  st.halt = 1'b1;
                        C_LETTER_E:  batch = put_byte(batch, st.halt, C_ESCAPE);
                        C_LETTER_F:  batch = put_byte(batch, st.halt, C_FORMFEED);
                        C_LETTER_N:  batch = put_byte(batch, st.halt, C_NEWLINE);
                        C_LETTER_T:  batch = put_byte(batch, st.halt, C_TAB);
                        C_LETTER_V:  batch = put_byte(batch, st.halt, C_VTAB);
                        C_DIGIT_0: begin
                            st.mode = MODE_OCTAL;
                            st.oval = '0;
                            st.odig = '0;
                        end
                        default: begin
                            batch = put_byte(batch, st.halt, C_BACKSLASH);
                            batch = put_byte(batch, st.halt, b);
                        end
                    endcase
                end
                MODE_OCTAL: begin
                    if (b inside {[C_DIGIT_0:C_DIGIT_7]}) begin
                        // Shift in one digit, emit after the third
                        st.oval = {st.oval[5:0], b[2:0]};
                        st.odig = dig_next;
                        if (dig_next == 2'd3) begin
                            batch   = put_byte(batch, st.halt, st.oval[7:0]);
                            st.mode = MODE_NORMAL;
                            st.oval = '0;
                            st.odig = '0;
                        end
                    end else begin
                        // Close the escape early, then treat the byte as text
                        if (st.odig != 2'd0) begin
                            batch = put_byte(batch, st.halt, st.oval[7:0]);
                        end
                        st.mode  = MODE_NORMAL;
                        st.oval  = '0;
                        st.odig  = '0;
                        do_plain = 1'b1;
                    end
                end
                default: do_plain = 1'b1;
            endcase

            if (do_plain) begin
                if (i_escapes_enabled && b == C_BACKSLASH) begin
                    st.mode = MODE_ESCAPE;
                end else begin
                    batch = put_byte(batch, st.halt, b);
                end
            end
        end

        // Flush a pending escape and add the separator at argument end
        if (ends) begin
            if (st.mode == MODE_ESCAPE) begin
                batch = put_byte(batch, st.halt, C_BACKSLASH);
            end else if (st.mode == MODE_OCTAL && st.odig != 2'd0) begin
                batch = put_byte(batch, st.halt, st.oval[7:0]);
            end
            st.mode = MODE_NORMAL;
            st.oval = '0;
            st.odig = '0;
            if (!i_item.ends_all) begin
                batch = put_byte(batch, st.halt, C_SPACE);
            end else begin
                if (i_newline_enabled) begin
                    batch = put_byte(batch, st.halt, C_NEWLINE);
                end
                st.halt = 1'b0;
            end
        end
    end

    assign o_batch = batch;
    assign o_state = st;

endmodule

// ----- rtl/core/eed_out_queue.sv -----
// Result register that holds one item's results and hands them out one per transfer.
module eed_out_queue
    import eed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_batch     i_batch,
    output logic       o_can_load,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic                         r_valid;
    logic [1:0]                   r_count;
    logic [1:0]                   r_idx;
    logic [MAX_RESULTS-1:0][7:0]  r_bytes;
    logic                         last;
    logic                         xfer;

    assign last       = (r_idx == r_count - 2'd1);
    assign xfer       = r_valid && i_ready;
    assign o_can_load = !r_valid || (xfer && last);
    assign o_valid    = r_valid;
    assign o_byte     = r_bytes[r_idx];
    assign o_last     = last;

    // Load a new batch when free, otherwise advance through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_count <= '0;
        end else if (i_load && o_can_load && i_batch.count != 2'd0) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
            r_count <= i_batch.count;
        end else if (xfer) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_bytes <= i_batch.bytes;
        end
    end

endmodule

// ----- rtl/core/echo_escape_decoder.sv -----
// Top level of the echo escape decoder: input register, decode state, configuration, result register.
//
// Argument bytes enter at one per cycle while o_in_ready is high. Each item is
// registered, decoded combinationally against the decode state, and its zero
// to three result bytes are loaded into the result register, which hands them
// out one per output transfer, so a result follows its item through the input
// register and the result register. An item with several results holds the
// output side until its last result is taken; the input side keeps one item per
// cycle only while each item yields at most one result. Configuration is always
// ready and is meant to be written only while no item is in flight.
module echo_escape_decoder
    import eed_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Argument byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_byte_present,
    input  logic                 i_ends_argument,
    input  logic                 i_ends_all,
    // Result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run,
    // Configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data
);

    logic    r_in_valid;
    t_item   r_item;
    t_dstate r_state;
    t_dstate n_state;
    logic    r_escapes_enabled;
    logic    r_newline_enabled;
    t_batch  batch;
    logic    can_load;
    logic    advance;

    assign advance     = r_in_valid && can_load;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    // Hold the accepted item until the result register can take its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{data_byte: i_data_byte, byte_present: i_byte_present,
                        ends_argument: i_ends_argument, ends_all: i_ends_all};
        end
    end

    // Advance decode state as each item is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_NORMAL, oval: '0, odig: '0, halt: 1'b0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escapes_enabled <= 1'b0;
            r_newline_enabled <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ESCAPES: r_escapes_enabled <= i_cfg_data;
                CFG_NEWLINE: r_newline_enabled <= i_cfg_data;
                default: ;
            endcase
        end
    end

    eed_decode u_decode (
        .i_item            (r_item),
        .i_state           (r_state),
        .i_escapes_enabled (r_escapes_enabled),
        .i_newline_enabled (r_newline_enabled),
        .o_batch           (batch),
        .o_state           (n_state)
    );

    eed_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_batch    (batch),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_byte     (o_out_byte),
        .o_last     (o_last_of_run)
    );

endmodule

// ----- rtl/core/eed_checker.sv -----
// Port-level checks of the echo escape decoder and their binding to the top level.
module eed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    // A stalled result holds its byte and mark
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
                                        && $stable(o_last_of_run))
        else $error("result changed while stalled");

    // No result is shown right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // Results of one run follow back to back
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && !o_last_of_run |=> o_out_valid)
        else $error("gap inside a run of results");

    // A fresh result is traced back to an earlier input transfer
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_xfer, 2))
        else $error("result without a matching input transfer");

endmodule

bind echo_escape_decoder eed_checker u_eed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

// ----- tb/tb_echo_escape_decoder.sv -----
// Self-checking testbench for echo_escape_decoder: directed table, random argument streams.
`timescale 1ns / 100ps

module tb_echo_escape_decoder;
    import eed_pkg::*;

    localparam int DRAIN_CYCLES     = 6;        // idle clocks after the last expected result
    localparam int LONG_HOLD_AFTER  = 60;       // items accepted before the long output stall
    localparam int LONG_HOLD_CYCLES = 100;
    localparam int TIMEOUT_NS       = 2_400_000;

    // Escape letters that decode to something other than backslash-char
    localparam logic [63:0] ESC_LETTERS = {C_LETTER_A, C_LETTER_B, C_LETTER_C, C_LETTER_E,
                                           C_LETTER_F, C_LETTER_N, C_LETTER_T, C_LETTER_V};

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_result;

    // One line of the directed script: either a register setting or an input item
    typedef struct {
        bit          is_cfg;
        logic        cfg_esc;
        logic        cfg_nl;
        t_item       item;
        int          n_typed;   // -1: results come from the decoder model below
        logic [23:0] typed;     // typed results, first byte in the top bits
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_data_byte;
    logic                 i_byte_present;
    logic                 i_ends_argument;
    logic                 i_ends_all;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [7:0]           o_out_byte;
    logic                 o_last_of_run;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;

    // Decoder model state and register copies, reset values
    logic       esc_on   = 1'b0;
    logic       nl_on    = 1'b1;
    t_mode      dec_mode = MODE_NORMAL;
    logic [8:0] oct_val  = '0;
    logic [1:0] oct_cnt  = '0;
    logic       dec_halt = 1'b0;

    logic [7:0] step_bytes [3];
    int         step_n;
    t_result    pending_out [$];
    t_result    want_out;
    t_row       script [$];
    logic [7:0] arg_text [$];

    int   mismatches     = 0;
    int   items_accepted = 0;
    int   burst_left     = 0;
    logic valid_held     = 1'b0;
    logic long_hold_done = 1'b0;

    echo_escape_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_ends_argument (i_ends_argument),
        .i_ends_all      (i_ends_all),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Append one output byte unless output is stopped or three are queued
    function automatic void emit(logic [7:0] value);
        if (!dec_halt && step_n < MAX_RESULTS) begin
            step_bytes[step_n] = value;
            step_n++;
        end
    endfunction

    // Text byte: open an escape or copy it
    function automatic void take_text(logic [7:0] b);
        if (esc_on && b == C_BACKSLASH)
            dec_mode = MODE_ESCAPE;
        else
            emit(b);
    endfunction

    // Work out the output bytes of one item and advance the decode state
    function automatic void decode_item(t_item it);
        logic [7:0] b;
        logic       arg_done;
        b        = it.data_byte;
        arg_done = it.ends_argument | it.ends_all;
        step_n   = 0;
        if (it.byte_present && !dec_halt) begin
            case (dec_mode)
                MODE_ESCAPE: begin
                    dec_mode = MODE_NORMAL;
                    case (b)
                        C_BACKSLASH: emit(C_BACKSLASH);
                        C_LETTER_A:  emit(C_BELL);
                        C_LETTER_B:  emit(C_BKSP);
                        C_LETTER_C:  dec_halt = 1'b1;
                        C_LETTER_E:  emit(C_ESCAPE);
                        C_LETTER_F:  emit(C_FORMFEED);
                        C_LETTER_N:  emit(C_NEWLINE);
                        C_LETTER_T:  emit(C_TAB);
                        C_LETTER_V:  emit(C_VTAB);
                        C_DIGIT_0: begin
                            dec_mode = MODE_OCTAL;
                            oct_val  = '0;
                            oct_cnt  = '0;
                        end
                        default: begin
                            emit(C_BACKSLASH);
                            emit(b);
                        end
                    endcase
                end
                MODE_OCTAL: begin
                    if (b >= C_DIGIT_0 && b <= C_DIGIT_7) begin
                        oct_val = {oct_val[5:0], b[2:0]};
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == 2'd3) begin
                            emit(oct_val[7:0]);
                            dec_mode = MODE_NORMAL;
                            oct_val  = '0;
                            oct_cnt  = '0;
                        end
                    end else begin
                        // Non-digit closes the octal escape, then counts as text
                        if (oct_cnt != 2'd0)
                            emit(oct_val[7:0]);
                        dec_mode = MODE_NORMAL;
                        oct_val  = '0;
                        oct_cnt  = '0;
                        take_text(b);
                    end
                end
                default: take_text(b);
            endcase
        end
        if (arg_done) begin
            // Flush a pending escape at the argument boundary
            if (dec_mode == MODE_ESCAPE)
                emit(C_BACKSLASH);
            else if (dec_mode == MODE_OCTAL && oct_cnt != 2'd0)
                emit(oct_val[7:0]);
            dec_mode = MODE_NORMAL;
            oct_val  = '0;
            oct_cnt  = '0;
            if (!it.ends_all) begin
                emit(C_SPACE);
            end else begin
                if (nl_on)
                    emit(C_NEWLINE);
                dec_halt = 1'b0;
            end
        end
    endfunction

    function automatic t_item mk_item(logic [7:0] d, logic p, logic ea, logic ef);
        t_item it;
        it.data_byte     = d;
        it.byte_present  = p;
        it.ends_argument = ea;
        it.ends_all      = ef;
        return it;
    endfunction

    function automatic t_row in_row(logic [7:0] d, logic p, logic ea, logic ef,
                                    int n = -1, logic [23:0] t = '0);
        t_row r;
        r.is_cfg  = 1'b0;
        r.cfg_esc = 1'b0;
        r.cfg_nl  = 1'b0;
        r.item    = mk_item(d, p, ea, ef);
        r.n_typed = n;
        r.typed   = t;
        return r;
    endfunction

    function automatic t_row cfg_row(logic esc, logic nl);
        t_row r;
        r         = in_row(8'h00, 1'b0, 1'b0, 1'b0);
        r.is_cfg  = 1'b1;
        r.cfg_esc = esc;
        r.cfg_nl  = nl;
        return r;
    endfunction

    // Add one token of argument text, biased toward escape sequences
    function automatic void add_token();
        case ($urandom_range(0, 7))
            0: arg_text.push_back(8'($urandom_range(8'h20, 8'h7E)));
            1: begin
                arg_text.push_back(C_BACKSLASH);
                arg_text.push_back(ESC_LETTERS[8 * $urandom_range(0, 7) +: 8]);
            end
            2, 3: begin
                arg_text.push_back(C_BACKSLASH);
                arg_text.push_back(C_DIGIT_0);
                repeat ($urandom_range(0, 3))
                    arg_text.push_back(C_DIGIT_0 + 8'($urandom_range(0, 7)));
            end
            4: begin
                arg_text.push_back(C_BACKSLASH);
                arg_text.push_back(8'($urandom));
            end
            5: arg_text.push_back(C_DIGIT_0 + 8'($urandom_range(0, 9)));
            6: arg_text.push_back(C_BACKSLASH);
            default: arg_text.push_back(8'($urandom));
        endcase
    endfunction

    // Offer one item in bursts, then queue its expected output on transfer
    task automatic send_item(input t_item it, input int n_typed = -1,
                             input logic [23:0] typed = '0);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= it.data_byte;
        i_byte_present  <= it.byte_present;
        i_ends_argument <= it.ends_argument;
        i_ends_all      <= it.ends_all;
        valid_held = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_accepted++;
        decode_item(it);
        if (n_typed >= 0) begin
            step_n = n_typed;
            for (int i = 0; i < MAX_RESULTS; i++)
                step_bytes[i] = typed[23 - 8 * i -: 8];
        end
        for (int i = 0; i < step_n; i++)
            pending_out.push_back('{value: step_bytes[i], last: (i == step_n - 1)});
        burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    // Drop input valid, wait for all expected output, then let the pipeline drain
    task automatic wait_idle();
        burst_left = 0;
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back
    task automatic set_config(input logic esc, input logic nl);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ESCAPES;
        i_cfg_data  <= esc;
        do @(posedge i_clk); while (!o_cfg_ready);
        esc_on = esc;
        i_cfg_index <= CFG_NEWLINE;
        i_cfg_data  <= nl;
        do @(posedge i_clk); while (!o_cfg_ready);
        nl_on = nl;
        i_cfg_valid <= 1'b0;
    endtask

    // Random runs of arguments, with loose items and ignored slots mixed in
    task automatic random_phase(input int quota);
        int    done_items;
        int    nargs;
        logic  truncated;
        logic  final_arg;
        logic  last_byte;
        t_item it;
        done_items = 0;
        while (done_items < quota) begin
            case ($urandom_range(0, 9))
                0: send_item(mk_item(8'($urandom), 1'b0, 1'b0, 1'b0));
                1: begin
                    it = 11'($urandom);
                    send_item(it);
                    if (it.byte_present || it.ends_argument || it.ends_all)
                        done_items++;
                end
                default: begin
                    nargs     = $urandom_range(1, 4);
                    truncated = ($urandom_range(0, 7) == 0);
                    for (int a = 0; a < nargs; a++) begin
                        final_arg = (a == nargs - 1) && !truncated;
                        arg_text.delete();
                        repeat ($urandom_range(0, 4)) add_token();
                        if (arg_text.size() == 0) begin
                            // Empty argument: no byte, only the end marks
                            send_item(mk_item(8'($urandom), 1'b0,
                                              !final_arg || 1'($urandom), final_arg));
                            done_items++;
                        end
                        for (int k = 0; k < arg_text.size(); k++) begin
                            last_byte = (k == arg_text.size() - 1);
                            send_item(mk_item(arg_text[k], 1'b1,
                                              last_byte && (!final_arg || 1'($urandom)),
                                              last_byte && final_arg));
                            done_items++;
                        end
                    end
                end
            endcase
        end
    endtask

    // Output checker: compare each transfer with the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected output byte: expected none, actual %h last %b",
                         $time, o_out_byte, o_last_of_run);
                mismatches++;
            end else begin
                want_out = pending_out.pop_front();
                if (o_out_byte !== want_out.value) begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want_out.value, o_out_byte);
                    mismatches++;
                end
                if (o_last_of_run !== want_out.last) begin
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want_out.last, o_last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Output ready: runs of stall styles, plus one long hold-off under load
    initial begin
        int stall_style;
        int run_len;
        i_out_ready = 1'b0;
        forever begin
            stall_style = $urandom_range(0, 3);
            run_len     = $urandom_range(4, 40);
            if (!long_hold_done && items_accepted >= LONG_HOLD_AFTER) begin
                @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            repeat (run_len) begin
                @(posedge i_clk);
                case (stall_style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain
    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_byte_present  = 1'b0;
        i_ends_argument = 1'b0;
        i_ends_all      = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_ESCAPES;
        i_cfg_data      = 1'b0;

        // Reset configuration: escapes copied, newline on
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 1, {C_BACKSLASH, 16'h0}));
        script.push_back(in_row(C_LETTER_N, 1, 0, 1, 2, {C_LETTER_N, C_NEWLINE, 8'h0}));
        script.push_back(cfg_row(1'b1, 1'b1));
        // Byte extremes
        script.push_back(in_row(8'h00, 1, 1, 0, 2, {8'h00, C_SPACE, 8'h0}));
        script.push_back(in_row(8'hFF, 1, 0, 0, 1, {8'hFF, 16'h0}));
        // Named escapes, escaped backslash, unknown escape letter
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(in_row(C_LETTER_A, 1, 0, 0));
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(in_row(C_LETTER_E, 1, 0, 0));
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0));
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(in_row(8'h71, 1, 0, 0));
        // Largest octal value wraps to 8 bits
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(in_row(C_DIGIT_0, 1, 0, 0, 0));
        script.push_back(in_row(C_DIGIT_7, 1, 0, 0, 0));
        script.push_back(in_row(C_DIGIT_7, 1, 0, 0, 0));
        script.push_back(in_row(C_DIGIT_7, 1, 0, 0, 1, {8'hFF, 16'h0}));
        // Octal cut short by a letter that also ends the argument
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0));
        script.push_back(in_row(C_DIGIT_0, 1, 0, 0));
        script.push_back(in_row(8'h35, 1, 0, 0));
        script.push_back(in_row(8'h7A, 1, 1, 0));
        // Bare octal escape
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0));
        script.push_back(in_row(C_DIGIT_0, 1, 0, 0));
        script.push_back(in_row(8'h6B, 1, 0, 0));
        // Trailing backslash at argument end
        script.push_back(in_row(C_BACKSLASH, 1, 1, 0, 2, {C_BACKSLASH, C_SPACE, 8'h0}));
        // Slot with no byte and no end, then an empty argument
        script.push_back(in_row(8'hA5, 0, 0, 0, 0));
        script.push_back(in_row(8'h5A, 0, 1, 0, 1, {C_SPACE, 16'h0}));
        // Escape pending while escapes get switched off
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(cfg_row(1'b0, 1'b1));
        script.push_back(in_row(C_LETTER_N, 1, 0, 0, 1, {C_NEWLINE, 16'h0}));
        script.push_back(cfg_row(1'b1, 1'b1));
        // Stop output: rest of the run, newline included, is dropped
        script.push_back(in_row(C_BACKSLASH, 1, 0, 0, 0));
        script.push_back(in_row(C_LETTER_C, 1, 0, 0, 0));
        script.push_back(in_row(8'h78, 1, 0, 1, 0));
        // Newline off, fresh run after the stop
        script.push_back(cfg_row(1'b1, 1'b0));
        script.push_back(in_row(8'h79, 1, 1, 1, 1, {8'h79, 16'h0}));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].is_cfg) begin
                wait_idle();
                set_config(script[r].cfg_esc, script[r].cfg_nl);
            end else begin
                send_item(script[r].item, script[r].n_typed, script[r].typed);
            end
        end

        // Random phases over all register settings
        wait_idle();
        set_config(1'b1, 1'b1);
        random_phase(80);
        wait_idle();
        set_config(1'b0, 1'b0);
        random_phase(30);
        wait_idle();
        set_config(1'b1, 1'b0);
        random_phase(80);
        wait_idle();
        set_config(1'b0, 1'b1);
        random_phase(30);

        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/eed_pkg.sv
rtl/core/eed_decode.sv
rtl/core/eed_out_queue.sv
rtl/core/echo_escape_decoder.sv
rtl/core/eed_checker.sv
tb/tb_echo_escape_decoder.sv
